@@ hdl/lcv_pkg.sv @@
// ----------------------------------------------------------------------------
// lcv_pkg
// Shared types and constants for the LZSS container validator.
// ----------------------------------------------------------------------------
package lcv_pkg;

    localparam int RECORD_BYTES = 24;
    localparam int NAME_BYTES   = 12;
    localparam int TDATA_W      = 184;
    localparam int FIFO_DEPTH   = 4;

    // register indexes on the config channel
    localparam logic [1:0] CFG_MAX_PACKED   = 2'd0;
    localparam logic [1:0] CFG_MAX_UNPACKED = 2'd1;
    localparam logic [1:0] CFG_MAX_MEMBERS  = 2'd2;

    localparam logic [30:0] MAX_PACKED_RST   = 31'd268435456;
    localparam logic [28:0] MAX_UNPACKED_RST = 29'd268435456;
    localparam logic [16:0] MAX_MEMBERS_RST  = 17'd100000;

    // status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_MAGIC     = 4'd1;
    localparam logic [3:0] ST_NAME      = 4'd2;
    localparam logic [3:0] ST_RESERVED  = 4'd3;
    localparam logic [3:0] ST_SIZE      = 4'd4;
    localparam logic [3:0] ST_TRUNCATED = 4'd5;
    localparam logic [3:0] ST_EMPTY     = 4'd6;
    localparam logic [3:0] ST_OVERLIMIT = 4'd7;
    localparam logic [3:0] ST_MEMBERS   = 4'd8;
    localparam logic [3:0] ST_OVERSIZE  = 4'd9;

    localparam logic [7:0] MAGIC_0 = 8'h46;
    localparam logic [7:0] MAGIC_1 = 8'h4D;
    localparam logic [7:0] MAGIC_2 = 8'h43;
    localparam logic [7:0] MAGIC_3 = 8'h31;

    localparam logic [32:0] POS_MAX   = 33'h1_FFFF_FFFF;
    localparam logic [32:0] POS_4GIB  = 33'h1_0000_0000;
    localparam logic [32:0] POS_SHORT = 33'd28;

    typedef struct packed {
        logic        kind;
        logic [16:0] member_number;
        logic [31:0] header_position;
        logic [31:0] payload_position;
        logic [30:0] packed_length;
        logic [28:0] unpacked_length;
        logic [31:0] dos_stamp;
        logic [3:0]  status_code;
        logic        last;
    } result_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = MAGIC_0;
            2'd1:    m = MAGIC_1;
            2'd2:    m = MAGIC_2;
            default: m = MAGIC_3;
        endcase
        return m;
    endfunction

endpackage

@@ hdl/lzss_container_validator.sv @@
// ----------------------------------------------------------------------------
// lzss_container_validator
// Byte-stream checker for an LZSS member archive.
// ----------------------------------------------------------------------------
// Usage: archive bytes enter on the s_ channel, one per transaction, with
// s_tlast on the last byte of the archive. Each byte is parsed in the cycle
// it is accepted; the member report and/or verdict it causes is written to a
// 4-entry result queue and shows on the m_ channel once the results ahead of it
// are taken. m_tuser marks a verdict, m_tlast the last result of a byte.
// Throughput: one byte per cycle while at least two queue entries are free, so
// the queue lets input run on while results wait. If the receiver stalls,
// s_tready drops once the queue holds three or more results.
// The verdict byte returns all parse state to reset, so the next byte starts
// a new archive. Limit registers are written on the cfg_ channel and keep
// their values across archives.
// Reset (aresetn low, synchronous): parse state cleared, queue emptied,
// limits return to their defaults.
// ----------------------------------------------------------------------------
module lzss_container_validator
    import lcv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte
    input  logic               s_tlast,   // final_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // member_number, header_position, payload_position, packed_length,
    // unpacked_length, dos_stamp, status_code, zero pad
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser,   // report_kind
    output logic               m_tlast,   // end_of_run
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_wdata
);

    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_RECORD  = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_HALT    = 3'd3;

    localparam logic [1:0] TP_START = 2'd0;
    localparam logic [1:0] TP_FLAG  = 2'd1;
    localparam logic [1:0] TP_MATCH = 2'd2;

    localparam logic [4:0] FC_NAME_END = 5'(NAME_BYTES);
    localparam logic [4:0] FC_LAST     = 5'(RECORD_BYTES - 1);

    // limits
    logic [30:0] max_packed_reg;
    logic [28:0] max_unpacked_reg;
    logic [16:0] max_members_reg;

    // parse state
    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  fc_reg, fc_next;
    logic [2:0]  nf_reg, nf_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [15:0] resv_reg, resv_next;
    logic [31:0] size_reg, size_next;
    logic [30:0] left_reg, left_next;
    logic [15:0] tf_reg, tf_next;
    logic [1:0]  tp_reg, tp_next;
    logic [29:0] oc_reg, oc_next;
    logic [32:0] pos_reg, pos_next;
    logic [31:0] hs_reg, hs_next;
    logic [16:0] members_reg, members_next;
    logic [3:0]  err_reg, err_next;

    // result queue
    result_t     q_reg [FIFO_DEPTH];
    logic [1:0]  head_reg, tail_reg;
    logic [2:0]  count_reg;

    logic        s_acc, m_acc;
    logic        mem_valid, ver_valid;
    result_t     mem_res, ver_res, e0, e1;
    logic        push0, push1;
    logic [4:0]  add_amt;
    logic        do_add;
    logic [15:0] tf_shift;
    logic        first;
    logic [3:0]  st;
    logic [31:0] pos32;

    assign s_acc     = s_tvalid & s_tready;
    assign m_acc     = m_tvalid & m_tready;
    assign s_tready  = (count_reg <= 3'd2);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_packed_reg   <= MAX_PACKED_RST;
            max_unpacked_reg <= MAX_UNPACKED_RST;
            max_members_reg  <= MAX_MEMBERS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MAX_PACKED:   max_packed_reg   <= cfg_wdata;
                CFG_MAX_UNPACKED: max_unpacked_reg <= cfg_wdata[28:0];
                CFG_MAX_MEMBERS:  max_members_reg  <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        fc_next      = fc_reg;
        nf_next      = nf_reg;
        stamp_next   = stamp_reg;
        resv_next    = resv_reg;
        size_next    = size_reg;
        left_next    = left_reg;
        tf_next      = tf_reg;
        tp_next      = tp_reg;
        oc_next      = oc_reg;
        hs_next      = hs_reg;
        members_next = members_reg;
        err_next     = err_reg;
        mem_valid    = 1'b0;
        ver_valid    = 1'b0;
        mem_res      = '0;
        ver_res      = '0;
        add_amt      = '0;
        do_add       = 1'b0;
        tf_shift     = '0;
        st           = ST_OK;
        pos32        = pos_reg[31:0];
        first        = (fc_reg == 5'd0);
        pos_next     = (pos_reg != POS_MAX) ? pos_reg + 33'd1 : pos_reg;

        unique case (phase_reg)
            PH_MAGIC: begin
                if (s_tdata != magic_byte(fc_reg[1:0])) begin
                    err_next   = ST_MAGIC;
                    phase_next = PH_HALT;
                end else if (fc_reg == 5'd3) begin
                    phase_next = PH_RECORD;
                    fc_next    = '0;
                end else begin
                    fc_next = fc_reg + 5'd1;
                end
            end
            PH_RECORD: begin
                if (first && members_reg >= max_members_reg) begin
                    err_next   = ST_MEMBERS;
                    phase_next = PH_HALT;
                end else begin
                    if (first) begin
                        hs_next    = pos32;
                        nf_next    = '0;
                        stamp_next = '0;
                        resv_next  = '0;
                        size_next  = '0;
                    end
                    if (fc_reg < FC_NAME_END) begin
                        if (!nf_next[0]) begin
                            if (s_tdata == 8'h00)
                                nf_next = nf_next | (first ? 3'd5 : 3'd1);
                            else if (s_tdata < 8'h20 || s_tdata > 8'h7e)
                                nf_next = nf_next | 3'd2;
                        end
                    end else if (fc_reg < 5'd16) begin
                        stamp_next[{fc_reg[1:0], 3'b000} +: 8] = s_tdata;
                    end else if (fc_reg == 5'd18 || fc_reg == 5'd19) begin
                        resv_next[{fc_reg[0], 3'b000} +: 8] = s_tdata;
                    end else if (fc_reg >= 5'd20) begin
                        size_next[{fc_reg[1:0], 3'b000} +: 8] = s_tdata;
                    end
                    fc_next = fc_reg + 5'd1;
                    if (fc_reg == FC_LAST) begin
                        fc_next = '0;
                        if (nf_next[2:1] != 2'b00)
                            st = ST_NAME;
                        else if (resv_next != 16'd0)
                            st = ST_RESERVED;
                        else if (size_next[31] || size_next == 32'd0 ||
                                 size_next[30:0] > max_packed_reg)
                            st = ST_SIZE;
                        if (st != ST_OK) begin
                            mem_valid                = 1'b1;
                            mem_res.member_number    = members_reg;
                            mem_res.header_position  = hs_reg;
                            mem_res.payload_position = hs_reg + 32'(RECORD_BYTES);
                            mem_res.packed_length    = size_next[30:0];
                            mem_res.dos_stamp        = stamp_next;
                            mem_res.status_code      = st;
                            err_next                 = st;
                            phase_next               = PH_HALT;
                        end else begin
                            phase_next = PH_PAYLOAD;
                            left_next  = size_next[30:0];
                            tf_next    = '0;
                            tp_next    = TP_START;
                            oc_next    = '0;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                if (tp_reg == TP_MATCH) begin
                    add_amt = {1'b0, s_tdata[3:0]} + 5'd3;
                    do_add  = 1'b1;
                    tp_next = TP_START;
                end else begin
                    tf_shift = {1'b0, tf_reg[15:1]};
                    if (tp_reg == TP_START && !tf_shift[8]) begin
                        tf_next = {8'hFF, s_tdata};
                        tp_next = TP_FLAG;
                    end else begin
                        if (tp_reg == TP_START)
                            tf_next = tf_shift;
                        if (tf_next[0]) begin
                            add_amt = 5'd1;
                            do_add  = 1'b1;
                            tp_next = TP_START;
                        end else begin
                            tp_next = TP_MATCH;
                        end
                    end
                end
                if (do_add && oc_reg <= {1'b0, max_unpacked_reg})
                    oc_next = oc_reg + 30'(add_amt);
                left_next = (left_reg != 31'd0) ? left_reg - 31'd1 : left_reg;
                if (left_next == 31'd0) begin
                    if (oc_next > {1'b0, max_unpacked_reg})
                        st = ST_OVERLIMIT;
                    else if (oc_next == 30'd0)
                        st = ST_EMPTY;
                    mem_valid                = 1'b1;
                    mem_res.member_number    = members_reg;
                    mem_res.header_position  = hs_reg;
                    mem_res.payload_position = hs_reg + 32'(RECORD_BYTES);
                    mem_res.packed_length    = size_reg[30:0];
                    mem_res.unpacked_length  = oc_next[28:0];
                    mem_res.dos_stamp        = stamp_reg;
                    mem_res.status_code      = st;
                    if (st != ST_OK) begin
                        err_next   = st;
                        phase_next = PH_HALT;
                    end else begin
                        members_next = members_reg + 17'd1;
                        phase_next   = PH_RECORD;
                        fc_next      = '0;
                    end
                end
            end
            default: ;
        endcase

        if (s_tlast) begin
            ver_valid             = 1'b1;
            ver_res.kind          = 1'b1;
            ver_res.member_number = members_next;
            if (pos_next > POS_4GIB)
                ver_res.status_code = ST_OVERSIZE;
            else if (pos_next < POS_SHORT)
                ver_res.status_code = ST_TRUNCATED;
            else if (err_next != ST_OK)
                ver_res.status_code = err_next;
            else if (phase_next != PH_RECORD || fc_next != 5'd0)
                ver_res.status_code = ST_TRUNCATED;
            else if (members_next == 17'd0)
                ver_res.status_code = ST_EMPTY;
            else
                ver_res.status_code = ST_OK;
            phase_next   = PH_MAGIC;
            fc_next      = '0;
            nf_next      = '0;
            stamp_next   = '0;
            resv_next    = '0;
            size_next    = '0;
            left_next    = '0;
            tf_next      = '0;
            tp_next      = TP_START;
            oc_next      = '0;
            pos_next     = '0;
            hs_next      = '0;
            members_next = '0;
            err_next     = ST_OK;
        end

        mem_res.last = !ver_valid;
        ver_res.last = 1'b1;
        e0    = mem_valid ? mem_res : ver_res;
        e1    = ver_res;
        push0 = s_acc && (mem_valid || ver_valid);
        push1 = s_acc && mem_valid && ver_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_MAGIC;
            fc_reg      <= '0;
            nf_reg      <= '0;
            stamp_reg   <= '0;
            resv_reg    <= '0;
            size_reg    <= '0;
            left_reg    <= '0;
            tf_reg      <= '0;
            tp_reg      <= TP_START;
            oc_reg      <= '0;
            pos_reg     <= '0;
            hs_reg      <= '0;
            members_reg <= '0;
            err_reg     <= ST_OK;
        end else if (s_acc) begin
            phase_reg   <= phase_next;
            fc_reg      <= fc_next;
            nf_reg      <= nf_next;
            stamp_reg   <= stamp_next;
            resv_reg    <= resv_next;
            size_reg    <= size_next;
            left_reg    <= left_next;
            tf_reg      <= tf_next;
            tp_reg      <= tp_next;
            oc_reg      <= oc_next;
            pos_reg     <= pos_next;
            hs_reg      <= hs_next;
            members_reg <= members_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0)
            q_reg[tail_reg] <= e0;
        if (push1)
            q_reg[tail_reg + 2'd1] <= e1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (m_acc)
                head_reg <= head_reg + 2'd1;
            tail_reg  <= tail_reg + {1'b0, push0} + {1'b0, push1};
            count_reg <= count_reg + {2'b00, push0} + {2'b00, push1} - {2'b00, m_acc};
        end
    end

    assign m_tvalid = (count_reg != 3'd0);
    assign m_tuser  = q_reg[head_reg].kind;
    assign m_tlast  = q_reg[head_reg].last;
    assign m_tdata  = {7'd0,
                       q_reg[head_reg].status_code,
                       q_reg[head_reg].dos_stamp,
                       q_reg[head_reg].unpacked_length,
                       q_reg[head_reg].packed_length,
                       q_reg[head_reg].payload_position,
                       q_reg[head_reg].header_position,
                       q_reg[head_reg].member_number};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_verdict_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> phase_reg == PH_MAGIC && pos_reg == 33'd0 &&
                             members_reg == 17'd0)
        else $error("parse state not cleared after verdict");

    a_halt_has_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HALT) == (err_reg != ST_OK))
        else $error("halt phase and kept error disagree");

    a_verdict_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("verdict not marked as last result");

endmodule
